// File: rtl/sot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sot_pkg: shared types and constants of the sample outbox table
// Table geometry, operation codes, header word, sequencer states and the
// control/status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sot_pkg;

	localparam int CAPACITY   = 32;
	localparam int MAX_VALUES = 8;
	localparam int CAP_W      = $clog2(CAPACITY);
	localparam int VAL_W      = $clog2(MAX_VALUES);
	localparam int VADDR_W    = CAP_W + VAL_W;
	localparam int NVAL_W     = 4;
	localparam int CNT_W      = 6;
	localparam int SLOT_W     = 5;
	localparam int VWORD_W    = 40;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_PUT    = 3'd1,
		OP_REMOVE = 3'd2,
		OP_FIND   = 3'd3,
		OP_DROP   = 3'd4,
		OP_READ   = 3'd5
	} op_e_t;

	typedef struct packed {
		logic [7:0]        origin;
		logic [15:0]       seq;
		logic [31:0]       capture;
		logic [31:0]       timestamp;
		logic              fixed;
		logic [NVAL_W-1:0] nval;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_CLEAR,
		ST_HDR,
		ST_CHECK,
		ST_VAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_issue;
		logic commit;
		logic clear_wr;
		logic hdr_issue;
		logic check;
		logic val_cap;
		logic done_load;
	} ctrl_t;

	typedef struct packed {
		logic  in_valid;
		op_e_t op_in;
		op_e_t op_q;
		logic  scan_last;
		logic  clr_last;
		logic  out_free;
	} stat_t;

	typedef struct packed {
		logic             have;
		logic [CAP_W-1:0] best_idx;
		hdr_t             best_hdr;
		logic             have_free;
		logic [CAP_W-1:0] free_idx;
	} cmp_res_t;

endpackage

// File: rtl/sot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sot_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sot_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sot_cmp: shared compare unit of the table scan
// One capture-time comparator and key match, applied to one entry per cycle;
// keeps the running best entry and the first free slot.
// ----------------------------------------------------------------------------
module sot_cmp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  eval,
	input  sot_pkg::op_e_t        op,
	input  logic [7:0]            key_origin,
	input  logic [15:0]           key_seq,
	input  logic [sot_pkg::CAP_W-1:0] idx,
	input  logic                  used,
	input  sot_pkg::hdr_t         hdr,
	output sot_pkg::cmp_res_t     res
);

	import sot_pkg::*;

	logic             have_q;
	logic             have_free_q;
	logic [CAP_W-1:0] best_idx_q;
	logic [CAP_W-1:0] free_idx_q;
	hdr_t             best_hdr_q;

	logic less;
	logic org_eq;
	logic seq_eq;
	logic cand;
	logic take;
	logic take_free;

	// the one comparator; ties keep the earlier (lower) slot
	assign less   = hdr.capture < best_hdr_q.capture;
	assign org_eq = hdr.origin == key_origin;
	assign seq_eq = hdr.seq == key_seq;

	always_comb begin
		case (op)
			OP_PUSH:   cand = used;
			OP_FIND:   cand = used && ((key_origin == 8'd0) || org_eq);
			OP_REMOVE: cand = used && org_eq && seq_eq;
			default:   cand = 1'b0;
		endcase
	end

	// remove takes the first match, the others the lowest capture time
	assign take      = eval && cand && (!have_q || ((op != OP_REMOVE) && less));
	assign take_free = eval && (op == OP_PUSH) && !used && !have_free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			have_free_q <= 1'b0;
		end else if (start) begin
			have_q      <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			if (take) begin
				have_q <= 1'b1;
			end
			if (take_free) begin
				have_free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx;
			best_hdr_q <= hdr;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	assign res.have      = have_q;
	assign res.best_idx  = best_idx_q;
	assign res.best_hdr  = best_hdr_q;
	assign res.have_free = have_free_q;
	assign res.free_idx  = free_idx_q;

endmodule

// File: rtl/sot_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sot_fsm: operation sequencer
// Steps one operation through scan, commit, value clear, header check and
// value read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sot_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  sot_pkg::stat_t stat,
	output sot_pkg::ctrl_t ctrl,
	output logic           idle
);

	import sot_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) begin
					case (stat.op_in)
						OP_PUSH, OP_REMOVE, OP_FIND: state_d = ST_SCAN;
						OP_PUT, OP_DROP, OP_READ:    state_d = ST_HDR;
						default:                     state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = (stat.op_q == OP_PUSH) ? ST_CLEAR : ST_DONE;
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_HDR:   state_d = ST_CHECK;
			ST_CHECK: state_d = (stat.op_q == OP_READ) ? ST_VAL : ST_DONE;
			ST_VAL:   state_d = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:   ctrl.accept     = stat.in_valid;
			ST_SCAN:   ctrl.scan_issue = 1'b1;
			ST_COMMIT: ctrl.commit     = 1'b1;
			ST_CLEAR:  ctrl.clear_wr   = 1'b1;
			ST_HDR:    ctrl.hdr_issue  = 1'b1;
			ST_CHECK:  ctrl.check      = 1'b1;
			ST_VAL:    ctrl.val_cap    = 1'b1;
			ST_DONE:   ctrl.done_load  = stat.out_free;
			default:   ctrl = '0;
		endcase
	end

	assign idle = state_q == ST_IDLE;

endmodule

// File: rtl/sample_outbox_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_outbox_table: fixed table of undelivered samples
// Push/put/remove/find/drop/read over a 32-entry table. Headers and value
// words live in RAMs; one shared compare unit walks the table a slot a cycle.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | op, origin, seq_num, capture_time, ...
//  out     | out_valid / out_ready | ok, slot_out, header fields, value_out,
//          |                       | status_out, entry_count
//
// Steps per beat: push = idle, a scan of every slot, drain, commit, a value
// clear of MAX_VALUES words and done; remove and find = idle, scan, drain,
// commit and done; put and drop = idle, header read, check and done; read
// adds a value read before done; an unknown op = idle and done. The scan
// length is set by the single header RAM read port, one slot per cycle into
// the shared comparator.
// One operation at a time: in_ready is high only while the sequencer idles.
// A finished result sits in the output register; the next beat may be taken
// while it waits, and that beat only stalls at its final step.
// Reset clears the used flags and the entry count at once; no clearing pass.
// ----------------------------------------------------------------------------
module sample_outbox_table (
	input  logic        clk,
	input  logic        arst_n,
	// input beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  origin,
	input  logic [15:0] seq_num,
	input  logic [31:0] capture_time,
	input  logic [31:0] timestamp,
	input  logic        timestamp_fixed,
	input  logic [7:0]  value_count,
	input  logic [4:0]  slot,
	input  logic [2:0]  value_index,
	input  logic [31:0] value_bits,
	input  logic [7:0]  value_status,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [4:0]  slot_out,
	output logic [7:0]  origin_out,
	output logic [15:0] seq_out,
	output logic [31:0] capture_out,
	output logic [31:0] timestamp_out,
	output logic        fixed_out,
	output logic [3:0]  count_out,
	output logic [31:0] value_out,
	output logic [7:0]  status_out,
	output logic [5:0]  entry_count
);

	import sot_pkg::*;

	// captured request
	op_e_t             op_q;
	logic [7:0]        origin_q;
	logic [15:0]       seq_q;
	logic [31:0]       cap_q;
	logic [31:0]       ts_q;
	logic              fixed_q;
	logic [NVAL_W-1:0] nval_q;
	logic [SLOT_W-1:0] slot_q;
	logic [2:0]        vidx_q;
	logic [31:0]       vbits_q;
	logic [7:0]        vst_q;

	// table state
	logic [CAPACITY-1:0] used_q;
	logic [CNT_W-1:0]    cnt_q;

	// sequencing counters and the scan read pipeline
	logic [CAP_W-1:0] idx_q;
	logic [VAL_W-1:0] clr_q;
	logic             eval_s1;
	logic [CAP_W-1:0] idx_s1;

	// staged result
	logic               res_ok_q;
	logic [VWORD_W-1:0] res_val_q;
	logic               out_valid_q;

	ctrl_t    ctrl;
	stat_t    stat;
	cmp_res_t cres;
	logic     idle;

	logic [NVAL_W-1:0] nval_sat;
	logic [CAP_W-1:0]  tgt;
	logic [CAP_W-1:0]  slot_idx;
	logic              slot_ok;
	logic              slot_used;
	logic              chk_ok;
	logic              hdr_found;

	// header RAM
	logic [CAP_W-1:0] hdr_raddr;
	hdr_t             hdr_wdata;
	logic [HDR_W-1:0] hdr_rbits;
	hdr_t             hdr_rd;

	// value RAM: {raw word, status byte}
	logic               val_we;
	logic [VADDR_W-1:0] val_waddr;
	logic [VWORD_W-1:0] val_wdata;
	logic [VADDR_W-1:0] val_raddr;
	logic [VWORD_W-1:0] val_rdata;

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	assign stat.in_valid  = in_valid;
	assign stat.op_in     = op_e_t'(op);
	assign stat.op_q      = op_q;
	assign stat.scan_last = idx_q == CAP_W'(CAPACITY - 1);
	assign stat.clr_last  = clr_q == VAL_W'(MAX_VALUES - 1);
	assign stat.out_free  = !out_valid_q || out_ready;

	sot_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	assign in_ready = idle;

	// ------------------------------------------------------------------------
	// request capture; value count saturates here
	// ------------------------------------------------------------------------
	assign nval_sat = (value_count > 8'(MAX_VALUES)) ? NVAL_W'(MAX_VALUES)
		: value_count[NVAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_PUSH;
		end else if (ctrl.accept) begin
			op_q <= op_e_t'(op);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			origin_q <= origin;
			seq_q    <= seq_num;
			cap_q    <= capture_time;
			ts_q     <= timestamp;
			fixed_q  <= timestamp_fixed;
			nval_q   <= nval_sat;
			slot_q   <= slot;
			vidx_q   <= value_index;
			vbits_q  <= value_bits;
			vst_q    <= value_status;
		end
	end

	// ------------------------------------------------------------------------
	// scan: one header read per cycle, evaluated in the next cycle and no later
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			clr_q   <= '0;
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= ctrl.scan_issue;
			if (ctrl.accept) begin
				idx_q <= '0;
				clr_q <= '0;
			end else begin
				if (ctrl.scan_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (ctrl.clear_wr) begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	assign hdr_raddr = ctrl.hdr_issue ? slot_idx : idx_q;
	assign hdr_rd    = hdr_t'(hdr_rbits);

	assign hdr_wdata.origin    = origin_q;
	assign hdr_wdata.seq       = seq_q;
	assign hdr_wdata.capture   = cap_q;
	assign hdr_wdata.timestamp = ts_q;
	assign hdr_wdata.fixed     = fixed_q;
	assign hdr_wdata.nval      = nval_q;

	sot_ram #(
		.WIDTH (HDR_W),
		.DEPTH (CAPACITY)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ctrl.commit && (op_q == OP_PUSH)),
		.waddr (tgt),
		.wdata (hdr_wdata),
		.raddr (hdr_raddr),
		.rdata (hdr_rbits)
	);

	sot_cmp u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ctrl.accept),
		.eval       (eval_s1),
		.op         (op_q),
		.key_origin (origin_q),
		.key_seq    (seq_q),
		.idx        (idx_s1),
		.used       (used_q[idx_s1]),
		.hdr        (hdr_rd),
		.res        (cres)
	);

	// full table: overwrite the oldest entry
	assign tgt       = cres.have_free ? cres.free_idx : cres.best_idx;
	assign hdr_found = cres.have && ((op_q == OP_REMOVE) || (op_q == OP_FIND));

	// ------------------------------------------------------------------------
	// slot checks for put, drop and read
	// ------------------------------------------------------------------------
	assign slot_idx  = slot_q[CAP_W-1:0];
	assign slot_ok   = {1'b0, slot_q} < (SLOT_W + 1)'(CAPACITY);
	assign slot_used = slot_ok && used_q[slot_idx];
	assign chk_ok    = slot_used && ({1'b0, vidx_q} < NVAL_W'(MAX_VALUES))
		&& (NVAL_W'(vidx_q) < hdr_rd.nval);

	// value RAM: cleared row after push, single word on put
	assign val_we    = ctrl.clear_wr || (ctrl.check && (op_q == OP_PUT) && chk_ok);
	assign val_waddr = ctrl.clear_wr ? {tgt, clr_q} : {slot_idx, vidx_q[VAL_W-1:0]};
	assign val_wdata = ctrl.clear_wr ? '0 : {vbits_q, vst_q};
	assign val_raddr = {slot_idx, vidx_q[VAL_W-1:0]};

	sot_ram #(
		.WIDTH (VWORD_W),
		.DEPTH (CAPACITY * MAX_VALUES)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// ------------------------------------------------------------------------
	// used flags and entry count
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q  <= '0;
		end else if (ctrl.commit) begin
			if (op_q == OP_PUSH) begin
				used_q[tgt] <= 1'b1;
				if (cres.have_free) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if ((op_q == OP_REMOVE) && cres.have) begin
				used_q[cres.best_idx] <= 1'b0;
				cnt_q                 <= cnt_q - 1'b1;
			end
		end else if (ctrl.check && (op_q == OP_DROP) && slot_used) begin
			used_q[slot_idx] <= 1'b0;
			cnt_q            <= cnt_q - 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// result staging
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ok_q <= 1'b0;
		end else if (ctrl.accept) begin
			res_ok_q <= 1'b0;
		end else if (ctrl.commit) begin
			res_ok_q <= (op_q == OP_PUSH) ? cres.have_free : cres.have;
		end else if (ctrl.check) begin
			res_ok_q <= (op_q == OP_DROP) ? slot_used : chk_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			res_val_q <= '0;
		end else if (ctrl.val_cap && res_ok_q) begin
			res_val_q <= val_rdata;
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done_load) begin
			ok          <= res_ok_q;
			entry_count <= cnt_q;
			case (op_q)
				OP_PUSH:           slot_out <= SLOT_W'(tgt);
				OP_PUT:            slot_out <= slot_q;
				OP_REMOVE, OP_FIND: slot_out <= cres.have ? SLOT_W'(cres.best_idx) : '0;
				default:           slot_out <= '0;
			endcase
			if (hdr_found) begin
				origin_out    <= cres.best_hdr.origin;
				seq_out       <= cres.best_hdr.seq;
				capture_out   <= cres.best_hdr.capture;
				timestamp_out <= cres.best_hdr.timestamp;
				fixed_out     <= cres.best_hdr.fixed;
				count_out     <= cres.best_hdr.nval;
			end else begin
				origin_out    <= '0;
				seq_out       <= '0;
				capture_out   <= '0;
				timestamp_out <= '0;
				fixed_out     <= 1'b0;
				count_out     <= '0;
			end
			if (op_q == OP_READ) begin
				value_out  <= res_val_q[VWORD_W-1:8];
				status_out <= res_val_q[7:0];
			end else begin
				value_out  <= '0;
				status_out <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sample outbox table
// A directed table of beats walks the corner cases, then mixed traffic that
// fills, churns and drains the table. Each accepted request is run through a
// behavioural copy of the outbox, and every result beat is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import sot_pkg::*;

	// Op codes the block does not define; they must leave the table alone.
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	// Directed rows either carry a hand-written answer or defer to the model.
	localparam logic TYPED    = 1'b1;
	localparam logic MODELLED = 1'b0;

	// Longest legal quiet spell is a push plus both idle draws;
	// this is many times that.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_TAIL  = 60;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

	// One request beat, field for field as on the input ports.
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  origin;
		logic [15:0] seq;
		logic [31:0] capture;
		logic [31:0] timestamp;
		logic        fixed;
		logic [7:0]  vcount;
		logic [4:0]  slot;
		logic [2:0]  vidx;
		logic [31:0] vbits;
		logic [7:0]  vstatus;
	} sample_req_t;

	// One result beat.
	typedef struct packed {
		logic        ok;
		logic [4:0]  slot;
		logic [7:0]  origin;
		logic [15:0] seq;
		logic [31:0] capture;
		logic [31:0] timestamp;
		logic        fixed;
		logic [3:0]  count;
		logic [31:0] value;
		logic [7:0]  status;
		logic [5:0]  entries;
	} outcome_t;

	typedef struct packed {
		sample_req_t req;
		logic        typed;
		outcome_t    want;
	} plan_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [7:0]  origin;
	logic [15:0] seq_num;
	logic [31:0] capture_time;
	logic [31:0] timestamp;
	logic        timestamp_fixed;
	logic [7:0]  value_count;
	logic [4:0]  slot;
	logic [2:0]  value_index;
	logic [31:0] value_bits;
	logic [7:0]  value_status;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [4:0]  slot_out;
	logic [7:0]  origin_out;
	logic [15:0] seq_out;
	logic [31:0] capture_out;
	logic [31:0] timestamp_out;
	logic        fixed_out;
	logic [3:0]  count_out;
	logic [31:0] value_out;
	logic [7:0]  status_out;
	logic [5:0]  entry_count;

	// Shadow of the table as the bench believes it to be.
	bit          tab_used [CAPACITY];
	bit          tab_ever [CAPACITY];   // slot has been pushed at least once
	hdr_t        tab_hdr  [CAPACITY];
	logic [31:0] tab_word [CAPACITY*MAX_VALUES];
	logic [7:0]  tab_stat [CAPACITY*MAX_VALUES];
	int          tab_count;
	int          ever_count;

	outcome_t pending_outcomes[$];
	int       mismatches;
	int       stall_cycles;
	bit       steady;                  // both sides run without idling

	sample_outbox_table u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.origin          (origin),
		.seq_num         (seq_num),
		.capture_time    (capture_time),
		.timestamp       (timestamp),
		.timestamp_fixed (timestamp_fixed),
		.value_count     (value_count),
		.slot            (slot),
		.value_index     (value_index),
		.value_bits      (value_bits),
		.value_status    (value_status),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ok              (ok),
		.slot_out        (slot_out),
		.origin_out      (origin_out),
		.seq_out         (seq_out),
		.capture_out     (capture_out),
		.timestamp_out   (timestamp_out),
		.fixed_out       (fixed_out),
		.count_out       (count_out),
		.value_out       (value_out),
		.status_out      (status_out),
		.entry_count     (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioural outbox: applies one request to the shadow table and returns
	// the beat the block should answer with. Fields an op does not name are 0.
	// ------------------------------------------------------------------------
	function automatic outcome_t outbox_apply(sample_req_t r);
		outcome_t res;
		int       i;
		int       tgt;
		int       best;
		int       base;
		bit       have;
		res  = '0;
		tgt  = -1;
		best = 0;
		have = 1'b0;
		base = int'(r.slot) * MAX_VALUES + int'(r.vidx);
		case (r.op)
			OP_PUSH: begin
				// first free slot; while none is free, track the oldest used
				// one (strict less-than keeps the lowest slot on a tie)
				for (i = 0; i < CAPACITY; i++) begin
					if (tgt < 0) begin
						if (!tab_used[i])
							tgt = i;
						else if (!have || tab_hdr[i].capture < tab_hdr[best].capture) begin
							best = i;
							have = 1'b1;
						end
					end
				end
				res.ok = (tgt >= 0);
				if (tgt < 0)
					tgt = best;
				else
					tab_count++;
				if (!tab_ever[tgt])
					ever_count++;
				tab_ever[tgt]            = 1'b1;
				tab_used[tgt]            = 1'b1;
				tab_hdr[tgt].origin      = r.origin;
				tab_hdr[tgt].seq         = r.seq;
				tab_hdr[tgt].capture     = r.capture;
				tab_hdr[tgt].timestamp   = r.timestamp;
				tab_hdr[tgt].fixed       = r.fixed;
				tab_hdr[tgt].nval        = (r.vcount > MAX_VALUES) ?
					NVAL_W'(MAX_VALUES) : NVAL_W'(r.vcount);
				for (i = 0; i < MAX_VALUES; i++) begin
					tab_word[tgt*MAX_VALUES + i] = '0;
					tab_stat[tgt*MAX_VALUES + i] = '0;
				end
				res.slot = 5'(tgt);
				have     = 1'b0;
			end
			OP_PUT: begin
				res.slot = r.slot;
				if (tab_used[r.slot] && r.vidx < tab_hdr[r.slot].nval) begin
					tab_word[base] = r.vbits;
					tab_stat[base] = r.vstatus;
					res.ok         = 1'b1;
				end
			end
			OP_REMOVE: begin
				for (i = 0; i < CAPACITY; i++) begin
					if (!have && tab_used[i] && tab_hdr[i].origin == r.origin &&
					    tab_hdr[i].seq == r.seq) begin
						best = i;
						have = 1'b1;
					end
				end
			end
			OP_FIND: begin
				for (i = 0; i < CAPACITY; i++) begin
					if (tab_used[i] && (r.origin == 8'd0 || tab_hdr[i].origin == r.origin) &&
					    (!have || tab_hdr[i].capture < tab_hdr[best].capture)) begin
						best = i;
						have = 1'b1;
					end
				end
			end
			OP_DROP: begin
				if (tab_used[r.slot]) begin
					tab_used[r.slot] = 1'b0;
					tab_count--;
					res.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (tab_used[r.slot] && r.vidx < tab_hdr[r.slot].nval) begin
					res.ok     = 1'b1;
					res.value  = tab_word[base];
					res.status = tab_stat[base];
				end
			end
			default: ;
		endcase
		// remove and find report the header of the entry they hit
		if (have && (r.op == OP_REMOVE || r.op == OP_FIND)) begin
			res.ok        = 1'b1;
			res.slot      = 5'(best);
			res.origin    = tab_hdr[best].origin;
			res.seq       = tab_hdr[best].seq;
			res.capture   = tab_hdr[best].capture;
			res.timestamp = tab_hdr[best].timestamp;
			res.fixed     = tab_hdr[best].fixed;
			res.count     = tab_hdr[best].nval;
			if (r.op == OP_REMOVE) begin
				tab_used[best] = 1'b0;
				tab_count--;
			end
		end
		res.entries = 6'(tab_count);
		return res;
	endfunction

	// Random slot among those in use, or among those ever pushed. Slots that
	// were never pushed are kept out of put, drop and read.
	function automatic int pick_slot(bit in_use);
		int pool[$];
		for (int i = 0; i < CAPACITY; i++)
			if (in_use ? tab_used[i] : tab_ever[i])
				pool.push_back(i);
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	// Mostly well-formed traffic: keys drawn from live entries, origins from
	// a handful of nodes, capture times often tied or at the extremes.
	function automatic sample_req_t random_beat(traffic_mix_t mix);
		sample_req_t r;
		int          p;
		int          k;
		int          s;
		int          push_pct;
		r.origin    = 8'($urandom);
		r.seq       = 16'($urandom);
		r.capture   = $urandom;
		r.timestamp = $urandom;
		r.fixed     = 1'($urandom);
		r.vcount    = 8'($urandom);
		r.slot      = 5'($urandom);
		r.vidx      = 3'($urandom);
		r.vbits     = $urandom;
		r.vstatus   = 8'($urandom);
		case (mix)
			MIX_FILL:     push_pct = 55;
			MIX_BALANCED: push_pct = 25;
			default:      push_pct = 8;
		endcase
		p = $urandom_range(0, 99);
		if (ever_count == 0 || p < push_pct)
			r.op = OP_PUSH;
		else if (p >= 98)
			r.op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
		else begin
			case ($urandom_range(0, 9))
				0, 1:    r.op = OP_PUT;
				2, 3:    r.op = OP_READ;
				4, 5:    r.op = OP_FIND;
				6, 7:    r.op = OP_REMOVE;
				default: r.op = OP_DROP;
			endcase
		end
		case (r.op)
			OP_PUSH: begin
				if ($urandom_range(0, 3) != 0)
					r.origin = 8'($urandom_range(1, 4));
				if ($urandom_range(0, 1) != 0)
					r.seq = 16'($urandom_range(0, 15));
				k = $urandom_range(0, 9);
				if (k < 4)
					r.capture = $urandom_range(0, 31);
				else if (k == 4)
					r.capture = 32'd0;
				else if (k == 5)
					r.capture = 32'hFFFF_FFFF;
				if ($urandom_range(0, 6) != 0)
					r.vcount = 8'($urandom_range(0, MAX_VALUES));
			end
			OP_REMOVE: begin
				if (tab_count != 0 && $urandom_range(0, 9) < 7) begin
					s        = pick_slot(1'b1);
					r.origin = tab_hdr[s].origin;
					r.seq    = tab_hdr[s].seq;
				end
			end
			OP_FIND: begin
				k = $urandom_range(0, 9);
				if (k < 4)
					r.origin = 8'd0;
				else if (k < 8 && tab_count != 0)
					r.origin = tab_hdr[pick_slot(1'b1)].origin;
			end
			OP_PUT, OP_READ, OP_DROP:
				r.slot = 5'(pick_slot(tab_count != 0 && $urandom_range(0, 4) != 0));
			default: ;
		endcase
		return r;
	endfunction

	function automatic sample_req_t beat(logic [2:0] o, logic [7:0] org, logic [15:0] sq,
			logic [31:0] cap, logic [31:0] ts, logic fx, logic [7:0] vc, logic [4:0] sl,
			logic [2:0] vi, logic [31:0] vb, logic [7:0] vs);
		sample_req_t r;
		r = '{o, org, sq, cap, ts, fx, vc, sl, vi, vb, vs};
		return r;
	endfunction

	// Answer with no header: only ok, slot, value word, status and fill level.
	function automatic outcome_t plain(logic k, logic [4:0] sl, logic [31:0] v,
			logic [7:0] st, logic [5:0] n);
		outcome_t res;
		res         = '0;
		res.ok      = k;
		res.slot    = sl;
		res.value   = v;
		res.status  = st;
		res.entries = n;
		return res;
	endfunction

	// Present one request beat from a falling edge and hold it until taken.
	// On a zero gap valid simply stays high into the next beat.
	task automatic send_beat(input sample_req_t r, input logic typed, input outcome_t w);
		int       gap;
		outcome_t model;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		op              <= r.op;
		origin          <= r.origin;
		seq_num         <= r.seq;
		capture_time    <= r.capture;
		timestamp       <= r.timestamp;
		timestamp_fixed <= r.fixed;
		value_count     <= r.vcount;
		slot            <= r.slot;
		value_index     <= r.vidx;
		value_bits      <= r.vbits;
		value_status    <= r.vstatus;
		do @(posedge clk); while (!in_ready);
		// the shadow table always advances; a typed row overrides the answer
		model = outbox_apply(r);
		pending_outcomes.push_back(typed ? w : model);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus: reset, directed rows, then nine segments of mixed traffic.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t    directed[$];
		traffic_mix_t mix;
		int           seg;
		in_valid        = 1'b0;
		op              = '0;
		origin          = '0;
		seq_num         = '0;
		capture_time    = '0;
		timestamp       = '0;
		timestamp_fixed = 1'b0;
		value_count     = '0;
		slot            = '0;
		value_index     = '0;
		value_bits      = '0;
		value_status    = '0;

		// empty table: nothing to find or remove
		directed.push_back(plan_row_t'{beat(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 0)});
		directed.push_back(plan_row_t'{beat(OP_REMOVE, 1, 5, 0, 0, 0, 0, 0, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 0)});
		// all-ones header, count saturates to the maximum; then all-zero header
		directed.push_back(plan_row_t'{beat(OP_PUSH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1, 8'hFF, 31, 7, 32'hFFFF_FFFF, 8'hFF),
			TYPED, plain(1, 0, 0, 0, 1)});
		directed.push_back(plan_row_t'{beat(OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			TYPED, plain(1, 1, 0, 0, 2)});
		directed.push_back(plan_row_t'{beat(OP_PUSH, 1, 7, 100, 5, 0, 8, 0, 0, 0, 0),
			TYPED, plain(1, 2, 0, 0, 3)});
		// last value of a saturated entry; put into a zero-count entry is refused
		directed.push_back(plan_row_t'{beat(OP_PUT, 0, 0, 0, 0, 0, 0, 0, 7,
			32'hFFFF_FFFF, 8'hFF), TYPED, plain(1, 0, 0, 0, 3)});
		directed.push_back(plan_row_t'{beat(OP_PUT, 0, 0, 0, 0, 0, 0, 1, 0,
			32'h1234, 8'h05), TYPED, plain(0, 1, 0, 0, 3)});
		directed.push_back(plan_row_t'{beat(OP_PUT, 0, 0, 0, 0, 0, 0, 2, 3,
			32'hA5A5_5A5A, 8'h3C), MODELLED, '0});
		directed.push_back(plan_row_t'{beat(OP_READ, 0, 0, 0, 0, 0, 0, 0, 7, 0, 0),
			TYPED, plain(1, 0, 32'hFFFF_FFFF, 8'hFF, 3)});
		// push cleared the rest of the slot
		directed.push_back(plan_row_t'{beat(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			TYPED, plain(1, 0, 0, 0, 3)});
		directed.push_back(plan_row_t'{beat(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 3)});
		directed.push_back(plan_row_t'{beat(OP_READ, 0, 0, 0, 0, 0, 0, 2, 3, 0, 0),
			MODELLED, '0});
		// oldest overall, oldest of one origin, origin with no entries
		directed.push_back(plan_row_t'{beat(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			MODELLED, '0});
		directed.push_back(plan_row_t'{beat(OP_FIND, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			MODELLED, '0});
		directed.push_back(plan_row_t'{beat(OP_FIND, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 3)});
		// undefined ops with busy payloads leave everything untouched
		directed.push_back(plan_row_t'{beat(OP_RSVD6, 8'h5A, 16'hA5A5, 32'h1234_5678,
			32'h9ABC_DEF0, 1, 3, 1, 5, 32'hDEAD_BEEF, 8'h77), TYPED, plain(0, 0, 0, 0, 3)});
		directed.push_back(plan_row_t'{beat(OP_RSVD7, 8'hA5, 16'h5A5A, 32'h8765_4321,
			32'h0FED_CBA9, 0, 8, 2, 2, 32'hCAFE_F00D, 8'h88), TYPED, plain(0, 0, 0, 0, 3)});
		// remove hit, then the same key misses
		directed.push_back(plan_row_t'{beat(OP_REMOVE, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 0, 0,
			0, 0), MODELLED, '0});
		directed.push_back(plan_row_t'{beat(OP_REMOVE, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 0, 0,
			0, 0), TYPED, plain(0, 0, 0, 0, 2)});
		// drop a used slot, drop it again, then touch the freed slot
		directed.push_back(plan_row_t'{beat(OP_DROP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
			TYPED, plain(1, 0, 0, 0, 1)});
		directed.push_back(plan_row_t'{beat(OP_DROP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 1)});
		directed.push_back(plan_row_t'{beat(OP_PUT, 0, 0, 0, 0, 0, 0, 1, 0, 32'h55, 8'h01),
			TYPED, plain(0, 1, 0, 0, 1)});
		directed.push_back(plan_row_t'{beat(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
			TYPED, plain(0, 0, 0, 0, 1)});
		// refill the lowest free slot with a capture time tied to slot 2
		directed.push_back(plan_row_t'{beat(OP_PUSH, 2, 3, 100, 7, 1, 2, 0, 0, 0, 0),
			TYPED, plain(1, 0, 0, 0, 2)});
		directed.push_back(plan_row_t'{beat(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			MODELLED, '0});

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_beat(directed[i].req, directed[i].typed, directed[i].want);

		// fill / churn / drain, three times over; two segments run flat out
		for (seg = 0; seg < 9; seg++) begin
			case (seg % 3)
				0:       mix = MIX_FILL;
				1:       mix = MIX_BALANCED;
				default: mix = MIX_DRAIN;
			endcase
			steady = (seg == 2 || seg == 6);
			repeat (97)
				send_beat(random_beat(mix), MODELLED, '0);
			// hold off until every outstanding result has come back
			in_valid <= 1'b0;
			while (pending_outcomes.size() != 0)
				@(negedge clk);
		end

		// let any stray beat show up before the verdict
		repeat (DRAIN_TAIL) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random hold-off before each beat, ready changes on falling
	// edges only and stays up across back-to-back beats.
	initial begin : result_sink
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = steady ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Scoreboard: each taken result beat against the oldest prediction.
	always @(posedge clk) begin : result_check
		outcome_t oldest;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				oldest = pending_outcomes.pop_front();
				check_field("ok", oldest.ok, ok);
				check_field("slot_out", oldest.slot, slot_out);
				check_field("origin_out", oldest.origin, origin_out);
				check_field("seq_out", oldest.seq, seq_out);
				check_field("capture_out", oldest.capture, capture_out);
				check_field("timestamp_out", oldest.timestamp, timestamp_out);
				check_field("fixed_out", oldest.fixed, fixed_out);
				check_field("count_out", oldest.count, count_out);
				check_field("value_out", oldest.value, value_out);
				check_field("status_out", oldest.status, status_out);
				check_field("entry_count", oldest.entries, entry_count);
			end
		end
	end

	// Watchdog: too long without a beat on either channel means a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
